[design/fixed_slot_free_list_allocator_macros.svh]
// Assertion helpers for the slot allocator; all checks run on clk and stop under reset.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define FSAL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold whenever the antecedent holds.
`define FSAL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/fsal_pkg.sv]
package fsal_pkg;

    // Fixed field widths
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int SHIFT_W    = 5;
    localparam int ADDR_W     = 64;
    localparam int BYTES_W    = 32;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    // Slot size limits, log2 of bytes
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_INIT    = 2'd3
    } op_e;

    typedef enum logic [3:0] {
        ST_POOLED      = 4'd0,
        ST_FALLBACK    = 4'd1,
        ST_FREED       = 4'd2,
        ST_EXT_FREE    = 4'd3,
        ST_NULL        = 4'd4,
        ST_KEPT        = 4'd5,
        ST_MOVED       = 4'd6,
        ST_EXT_REALLOC = 4'd7,
        ST_INIT        = 4'd8
    } status_e;

    typedef enum logic [1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_SLOT_COUNT   = 2'd1,
        REG_SLOT_SHIFT   = 2'd2
    } reg_idx_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_INIT,
        S_RESULT
    } state_e;

    typedef struct packed {
        logic [ADDR_W-1:0]  base_address;
        logic [COUNT_W-1:0] slot_count;
        logic [SHIFT_W-1:0] slot_shift;
    } cfg_t;

    typedef struct packed {
        status_e           status;
        logic [ADDR_W-1:0] address;
        logic [SLOT_W-1:0] slot;
    } res_t;

endpackage

[design/fsal_ram.sv]
module fsal_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/fsal_cfg.sv]
module fsal_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsal_pkg::PADDR_W-1:0] paddr,
    input  logic [fsal_pkg::PDATA_W-1:0] pwdata,
    output logic [fsal_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output fsal_pkg::cfg_t               cfg
);

    logic [fsal_pkg::ADDR_W-1:0]  base_reg;
    logic [fsal_pkg::COUNT_W-1:0] count_reg;
    logic [fsal_pkg::SHIFT_W-1:0] shift_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Take a register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= '0;
            shift_reg <= fsal_pkg::SHIFT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[4:3])
                fsal_pkg::REG_BASE_ADDRESS: base_reg  <= pwdata;
                fsal_pkg::REG_SLOT_COUNT:   count_reg <= pwdata[fsal_pkg::COUNT_W-1:0];
                fsal_pkg::REG_SLOT_SHIFT:   shift_reg <= pwdata[fsal_pkg::SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (paddr[4:3])
            fsal_pkg::REG_BASE_ADDRESS: prdata = base_reg;
            fsal_pkg::REG_SLOT_COUNT:   prdata = fsal_pkg::PDATA_W'(count_reg);
            fsal_pkg::REG_SLOT_SHIFT:   prdata = fsal_pkg::PDATA_W'(shift_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.base_address = base_reg;
    assign cfg.slot_count   = count_reg;
    assign cfg.slot_shift   = shift_reg;

endmodule

[design/fsal_ctrl.sv]
module fsal_ctrl #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fsal_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  fsal_pkg::op_e                         in_op,
    input  logic [fsal_pkg::ADDR_W-1:0]           in_address,
    input  logic [fsal_pkg::BYTES_W-1:0]          in_bytes,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output fsal_pkg::res_t                        res,
    output logic [$clog2(MAX_SLOTS+1)-1:0]        free_count,
    output logic                                  ram_we,
    output logic [$clog2(MAX_SLOTS)-1:0]          ram_waddr,
    output logic [fsal_pkg::SLOT_W-1:0]           ram_wdata,
    output logic [$clog2(MAX_SLOTS)-1:0]          ram_raddr,
    input  logic [fsal_pkg::SLOT_W-1:0]           ram_rdata
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int AW    = $clog2(MAX_SLOTS);

    fsal_pkg::state_e             state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             ctr_reg, ctr_next;
    fsal_pkg::res_t               res_reg, res_next;
    fsal_pkg::op_e                op_reg;
    logic [fsal_pkg::ADDR_W-1:0]  addr_reg;
    logic [fsal_pkg::ADDR_W-1:0]  diff_reg;
    logic [fsal_pkg::BYTES_W-1:0] bytes_reg;

    logic [fsal_pkg::SHIFT_W-1:0] sh;
    logic [CNT_W-1:0]             eff_count;
    logic [CNT_W-1:0]             count_dec;
    logic [fsal_pkg::ADDR_W-1:0]  idx;
    logic                         in_pool;
    logic                         fits;
    logic                         addr_null;
    logic                         want_alloc;
    logic                         can_push;

    // Saturate the configured shift and count
    always_comb
    begin
        if (cfg.slot_shift < fsal_pkg::SHIFT_MIN)
        begin
            sh = fsal_pkg::SHIFT_MIN;
        end
        else if (cfg.slot_shift > fsal_pkg::SHIFT_MAX)
        begin
            sh = fsal_pkg::SHIFT_MAX;
        end
        else
        begin
            sh = cfg.slot_shift;
        end
        if (32'(cfg.slot_count) > MAX_SLOTS)
        begin
            eff_count = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            eff_count = CNT_W'(cfg.slot_count);
        end
    end

    // Map the held address offset to a slot and size the request
    assign idx        = diff_reg >> sh;
    assign in_pool    = ((idx >> CNT_W) == '0) && (idx[CNT_W-1:0] < eff_count);
    assign fits       = {1'b0, bytes_reg} <= (33'd1 << sh);
    assign addr_null  = (addr_reg == '0);
    assign want_alloc = (op_reg == fsal_pkg::OP_ALLOC) ||
                        ((op_reg == fsal_pkg::OP_REALLOC) && addr_null);
    assign can_push   = (count_reg < MAX_SLOTS);
    assign count_dec  = count_reg - CNT_W'(1);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsal_pkg::S_IDLE;
            count_reg <= '0;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ctr_reg   <= ctr_next;
        end
    end

    // Capture the accepted word and the pending result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= in_op;
            addr_reg  <= in_address;
            bytes_reg <= in_bytes;
            diff_reg  <= in_address - cfg.base_address;
        end
        res_reg <= res_next;
    end

    // Sequence one operation through the stack memory
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctr_next   = ctr_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = idx[fsal_pkg::SLOT_W-1:0];
        ram_raddr  = count_dec[AW-1:0];

        case (state_reg)
            fsal_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = fsal_pkg::S_EXEC;
                end
            end

            fsal_pkg::S_EXEC:
            begin
                state_next       = fsal_pkg::S_RESULT;
                res_next.address = '0;
                res_next.slot    = '0;
                if (op_reg == fsal_pkg::OP_INIT)
                begin
                    ctr_next   = '0;
                    state_next = fsal_pkg::S_INIT;
                end
                else if (want_alloc)
                begin
                    // Pop the top entry or fall back
                    if ((count_reg == '0) || !fits)
                    begin
                        res_next.status = fsal_pkg::ST_FALLBACK;
                    end
                    else
                    begin
                        count_next = count_dec;
                        state_next = fsal_pkg::S_READ;
                    end
                end
                else if (addr_null)
                begin
                    res_next.status = fsal_pkg::ST_NULL;
                end
                else if (!in_pool)
                begin
                    res_next.status = (op_reg == fsal_pkg::OP_FREE) ?
                                      fsal_pkg::ST_EXT_FREE : fsal_pkg::ST_EXT_REALLOC;
                end
                else if ((op_reg == fsal_pkg::OP_REALLOC) && fits)
                begin
                    res_next.status  = fsal_pkg::ST_KEPT;
                    res_next.address = addr_reg;
                    res_next.slot    = idx[fsal_pkg::SLOT_W-1:0];
                end
                else
                begin
                    // Release the slot; drop the push on a full stack
                    res_next.status = (op_reg == fsal_pkg::OP_FREE) ?
                                      fsal_pkg::ST_FREED : fsal_pkg::ST_MOVED;
                    res_next.slot   = idx[fsal_pkg::SLOT_W-1:0];
                    if (can_push)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            fsal_pkg::S_READ:
            begin
                res_next.status  = fsal_pkg::ST_POOLED;
                res_next.slot    = ram_rdata;
                res_next.address = cfg.base_address +
                                   (fsal_pkg::ADDR_W'(ram_rdata) << sh);
                state_next       = fsal_pkg::S_RESULT;
            end

            fsal_pkg::S_INIT:
            begin
                // Sweep slot numbers into the stack, one entry a cycle
                if (ctr_reg < eff_count)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ctr_reg[AW-1:0];
                    ram_wdata = fsal_pkg::SLOT_W'(ctr_reg);
                    ctr_next  = ctr_reg + CNT_W'(1);
                end
                else
                begin
                    count_next       = eff_count;
                    res_next.status  = fsal_pkg::ST_INIT;
                    res_next.address = '0;
                    res_next.slot    = '0;
                    state_next       = fsal_pkg::S_RESULT;
                end
            end

            fsal_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = fsal_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fsal_pkg::S_IDLE;
            end
        endcase
    end

    assign res        = res_reg;
    assign free_count = count_reg;

endmodule

[design/fixed_slot_free_list_allocator.sv]
// Each accepted word passes the execute state; a pooled alloc adds a stack RAM read state,
// init adds a sweep over the slot count, and the result state hands on the result word.
// One operation in flight; the next word is taken once the result sits in the output
// register, so no word is taken while the last result waits on a stalled output.
// Reset clears the free count, the control state and the registers (slot shift to 1);
// the stack RAM is not cleared, only entries below the free count are ever read.
`include "fixed_slot_free_list_allocator_macros.svh"

module fixed_slot_free_list_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsal_pkg::IN_DATA_W-1:0]  s_tdata,   // address[63:0], request_bytes[95:64]
    input  logic [1:0]                      s_tuser,   // operation[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsal_pkg::OUT_DATA_W-1:0] m_tdata,   // result_address[63:0], slot_index[73:64]
    output logic [3:0]                      m_tuser,   // status[3:0]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsal_pkg::PADDR_W-1:0]    paddr,
    input  logic [fsal_pkg::PDATA_W-1:0]    pwdata,
    output logic [fsal_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int AW    = $clog2(MAX_SLOTS);

    fsal_pkg::cfg_t               cfg;
    fsal_pkg::res_t               res;
    fsal_pkg::res_t               out_res_reg;
    logic                         out_valid_reg;
    logic                         res_valid;
    logic                         res_ready;
    logic [CNT_W-1:0]             free_count;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [fsal_pkg::SLOT_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [fsal_pkg::SLOT_W-1:0]  ram_rdata;

    fsal_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fsal_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (fsal_pkg::op_e'(s_tuser)),
        .in_address (s_tdata[63:0]),
        .in_bytes   (s_tdata[95:64]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .free_count (free_count),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    fsal_ram #(
        .WIDTH (fsal_pkg::SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.slot, out_res_reg.address};
    assign m_tuser  = out_res_reg.status;

    `FSAL_ASSERT_ALWAYS(a_count_bound, free_count <= MAX_SLOTS, "free count above pool size")
    `FSAL_ASSERT_IMPLIES(a_idle_no_result, s_tready, !res_valid, "result pending while idle")
    `FSAL_ASSERT_IMPLIES(a_pooled_slot, m_tvalid && (m_tuser == fsal_pkg::ST_POOLED), m_tdata[73:64] < MAX_SLOTS, "pooled slot out of range")
    `FSAL_ASSERT_IMPLIES(a_fallback_zero, m_tvalid && (m_tuser == fsal_pkg::ST_FALLBACK), m_tdata == '0, "fallback word not zero")

endmodule
